FILE: sv/sss_pkg.sv
`timescale 1ns / 1ps

package sss_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MINUTES      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERFACE_STEPS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUMP_PERIOD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROJECTION_STEPS = 3'd4;

    localparam int unsigned CFG_DATA_W = 32;

    // Calendar limits.
    localparam logic [5:0] MAX_STEP        = 6'd60;
    localparam logic [6:0] MINUTES_PER_HOUR = 7'd60;
    localparam logic [5:0] HOURS_PER_DAY    = 6'd24;

    // Reset values of the configuration registers.
    localparam logic [5:0]  RST_BASE_STEP        = 6'd60;
    localparam logic [31:0] RST_END_MINUTES      = 32'd0;
    localparam logic [15:0] RST_INTERFACE_STEPS  = 16'd24;
    localparam logic [15:0] RST_DUMP_PERIOD      = 16'd1;
    localparam logic [15:0] RST_PROJECTION_STEPS = 16'd24;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 128;

    typedef struct packed {
        logic [5:0]  base_step;
        logic [31:0] end_minutes;
        logic [15:0] interface_steps;
        logic [15:0] dump_period;
        logic [15:0] projection_steps;
    } cfg_t;

    typedef struct packed {
        logic        complete;
        logic [31:0] elapsed_minutes;
        logic [4:0]  hour_of_day;
        logic [15:0] day_of_sim;
        logic [15:0] commit_step;
        logic [15:0] index_previous;
        logic [15:0] index_current;
        logic [15:0] index_next;
        logic        commit_flag;
        logic        projection_flag;
        logic        dump_flag;
    } result_t;

endpackage

FILE: sv/sss_cfg_regs.sv
`timescale 1ns / 1ps

module sss_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [sss_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0]    wr_data,
    output sss_pkg::cfg_t                     cfg
);

    sss_pkg::cfg_t cfg_reg;
    sss_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                sss_pkg::REG_BASE_STEP:        cfg_next.base_step        = wr_data[5:0];
                sss_pkg::REG_END_MINUTES:      cfg_next.end_minutes      = wr_data[31:0];
                sss_pkg::REG_INTERFACE_STEPS:  cfg_next.interface_steps  = wr_data[15:0];
                sss_pkg::REG_DUMP_PERIOD:      cfg_next.dump_period      = wr_data[15:0];
                sss_pkg::REG_PROJECTION_STEPS: cfg_next.projection_steps = wr_data[15:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_step        <= sss_pkg::RST_BASE_STEP;
            cfg_reg.end_minutes      <= sss_pkg::RST_END_MINUTES;
            cfg_reg.interface_steps  <= sss_pkg::RST_INTERFACE_STEPS;
            cfg_reg.dump_period      <= sss_pkg::RST_DUMP_PERIOD;
            cfg_reg.projection_steps <= sss_pkg::RST_PROJECTION_STEPS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/sss_tick_core.sv
`timescale 1ns / 1ps

module sss_tick_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic             advance,
    input  sss_pkg::cfg_t    cfg,
    output sss_pkg::result_t result
);

    // Event flag bit positions.
    localparam int unsigned FL_CUR_COMMIT = 0;
    localparam int unsigned FL_CUR_PROJ   = 1;
    localparam int unsigned FL_CUR_DUMP   = 2;
    localparam int unsigned FL_NXT_COMMIT = 3;
    localparam int unsigned FL_NXT_PROJ   = 4;
    localparam int unsigned FL_NXT_DUMP   = 5;
    localparam logic [5:0] FLAGS_RESET = 6'b001110;

    logic [31:0] minutes_reg,   minutes_next;
    logic [5:0]  a_minute_reg,  a_minute_next;
    logic [4:0]  a_hour_reg,    a_hour_next;
    logic [15:0] a_day_reg,     a_day_next;
    logic [4:0]  n_hour_reg,    n_hour_next;
    logic [15:0] n_day_reg,     n_day_next;
    logic [15:0] a_commit_reg,  a_commit_next;
    logic [15:0] n_commit_reg,  n_commit_next;
    logic [5:0]  flags_reg,     flags_next;
    logic [16:0] dump_cnt_reg,  dump_cnt_next;
    logic [15:0] idx_prev_reg,  idx_prev_next;
    logic [15:0] idx_cur_reg,   idx_cur_next;
    logic [15:0] idx_nxt_reg,   idx_nxt_next;

    logic        complete;
    logic        do_tick;
    logic [5:0]  step;
    logic [32:0] minutes_sum;
    logic [6:0]  minute_sum;
    logic        minute_wrap;
    logic [5:0]  hour_inc;
    logic [16:0] commit_inc;
    logic        commit_wrap;
    logic        dump_hit;
    logic [16:0] dump_base;
    logic [16:0] idx_inc;
    logic [5:0]  nf;

    assign complete = (minutes_reg >= cfg.end_minutes);
    assign do_tick  = step_en && advance && !complete;
    assign step     = (cfg.base_step > sss_pkg::MAX_STEP) ? sss_pkg::MAX_STEP : cfg.base_step;

    always_comb
    begin
        minutes_sum = {1'b0, minutes_reg} + {27'd0, step};
        minute_sum  = {1'b0, a_minute_reg} + {1'b0, step};
        minute_wrap = (minute_sum >= sss_pkg::MINUTES_PER_HOUR);
        hour_inc    = {1'b0, a_hour_reg} + 6'd1;
        commit_inc  = {1'b0, a_commit_reg} + 17'd1;
        commit_wrap = (commit_inc >= {1'b0, cfg.projection_steps});
        dump_hit    = (dump_cnt_reg == {1'b0, cfg.dump_period});
        dump_base   = dump_hit ? 17'd0 : dump_cnt_reg;
        idx_inc     = {1'b0, idx_nxt_reg} + 17'd1;

        nf = 6'd0;
        nf[FL_CUR_COMMIT] = flags_reg[FL_NXT_COMMIT];
        nf[FL_CUR_PROJ]   = flags_reg[FL_NXT_PROJ];
        nf[FL_CUR_DUMP]   = flags_reg[FL_NXT_DUMP];
        nf[FL_NXT_COMMIT] = 1'b1;
        nf[FL_NXT_PROJ]   = commit_wrap;
        nf[FL_NXT_DUMP]   = dump_hit;

        minutes_next  = minutes_reg;
        a_minute_next = a_minute_reg;
        a_hour_next   = a_hour_reg;
        a_day_next    = a_day_reg;
        n_hour_next   = n_hour_reg;
        n_day_next    = n_day_reg;
        a_commit_next = a_commit_reg;
        n_commit_next = n_commit_reg;
        flags_next    = flags_reg;
        dump_cnt_next = dump_cnt_reg;
        idx_prev_next = idx_prev_reg;
        idx_cur_next  = idx_cur_reg;
        idx_nxt_next  = idx_nxt_reg;

        if (do_tick)
        begin
            // Elapsed time saturates at the top of its range.
            minutes_next = minutes_sum[32] ? 32'hFFFF_FFFF : minutes_sum[31:0];
            n_hour_next  = a_hour_reg;
            n_day_next   = a_day_reg;
            if (minute_wrap)
            begin
                a_minute_next = 6'(minute_sum - sss_pkg::MINUTES_PER_HOUR);
                if (hour_inc >= sss_pkg::HOURS_PER_DAY)
                begin
                    a_hour_next = 5'(hour_inc - sss_pkg::HOURS_PER_DAY);
                    if (a_day_reg != 16'hFFFF)
                    begin
                        a_day_next = a_day_reg + 16'd1;
                    end
                end
                else
                begin
                    a_hour_next = hour_inc[4:0];
                end
            end
            else
            begin
                a_minute_next = minute_sum[5:0];
            end
            n_commit_next = a_commit_reg;
            a_commit_next = commit_wrap ? 16'd0 : commit_inc[15:0];
            dump_cnt_next = dump_base + 17'd1;
            flags_next    = nf;
            idx_prev_next = idx_cur_reg;
            idx_cur_next  = idx_nxt_reg;
            idx_nxt_next  = (idx_inc >= {1'b0, cfg.interface_steps}) ? 16'd0 : idx_inc[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minutes_reg  <= 32'd0;
            a_minute_reg <= 6'd0;
            a_hour_reg   <= 5'd1;
            a_day_reg    <= 16'd0;
            n_hour_reg   <= 5'd0;
            n_day_reg    <= 16'd0;
            a_commit_reg <= 16'd1;
            n_commit_reg <= 16'd0;
            flags_reg    <= FLAGS_RESET;
            dump_cnt_reg <= 17'h1FFFF;
            idx_prev_reg <= 16'd0;
            idx_cur_reg  <= 16'd0;
            idx_nxt_reg  <= 16'd1;
        end
        else
        begin
            minutes_reg  <= minutes_next;
            a_minute_reg <= a_minute_next;
            a_hour_reg   <= a_hour_next;
            a_day_reg    <= a_day_next;
            n_hour_reg   <= n_hour_next;
            n_day_reg    <= n_day_next;
            a_commit_reg <= a_commit_next;
            n_commit_reg <= n_commit_next;
            flags_reg    <= flags_next;
            dump_cnt_reg <= dump_cnt_next;
            idx_prev_reg <= idx_prev_next;
            idx_cur_reg  <= idx_cur_next;
            idx_nxt_reg  <= idx_nxt_next;
        end
    end

    // The result reflects the state as it stands after this item; complete reflects the state before it.
    always_comb
    begin
        result.complete        = complete;
        result.elapsed_minutes = minutes_next;
        result.hour_of_day     = n_hour_next;
        result.day_of_sim      = n_day_next;
        result.commit_step     = n_commit_next;
        result.index_previous  = idx_prev_next;
        result.index_current   = idx_cur_next;
        result.index_next      = idx_nxt_next;
        result.commit_flag     = flags_next[FL_CUR_COMMIT];
        result.projection_flag = flags_next[FL_CUR_PROJ];
        result.dump_flag       = flags_next[FL_CUR_DUMP];
    end

    a_minute_range: assert property (@(posedge clk) disable iff (!rst_n)
        a_minute_reg < 6'd60)
        else $error("look-ahead minute out of range");

    a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
        (a_hour_reg < 5'd24) && (n_hour_reg < 5'd24))
        else $error("hour out of range");

    a_complete_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && complete) |=> $stable(minutes_reg) && $stable(idx_nxt_reg))
        else $error("state changed on a completed run");

endmodule

FILE: sv/simulation_step_scheduler.sv
`timescale 1ns / 1ps

// A tick transferred on s_* is held in the input stage, then processed into the result
// register once that register is free or drains, and its result then transfers on m_*.
// Throughput: one tick per clock while m_tready is high; the whole update is a single add/compare/wrap pass.
// A waiting result still leaves room for one tick in the input stage; then s_tready drops.
// Reset (rst_n low, asynchronous) clears both stages, loads the configuration defaults
// and puts the calendar, counters, flags and interface indices at their start values.
module simulation_step_scheduler (
    input  logic                               clk,
    input  logic                               rst_n,

    // Tick stream. s_tdata fields from bit 0 up: advance.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sss_pkg::IN_TDATA_W-1:0]     s_tdata,

    // Result stream. m_tdata fields from bit 0 up: complete, elapsed_minutes,
    // hour_of_day, day_of_sim, commit_step, index_previous, index_current,
    // index_next, commit_flag, projection_flag, dump_flag.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sss_pkg::OUT_TDATA_W-1:0]    m_tdata,

    // Configuration writes, always accepted.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0]     cfg_data
);

    sss_pkg::cfg_t    cfg;
    sss_pkg::result_t result;
    sss_pkg::result_t out_reg;

    logic stage_valid_reg, stage_valid_next;
    logic stage_adv_reg,   stage_adv_next;
    logic out_valid_reg,   out_valid_next;
    logic move;

    assign cfg_ready = 1'b1;

    sss_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The staged tick is processed when the result register is free or drains this cycle.
    assign move     = stage_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !stage_valid_reg || move;

    sss_tick_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (move),
        .advance (stage_adv_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_adv_next   = stage_adv_reg;
        if (s_tready)
        begin
            stage_valid_next = s_tvalid;
            stage_adv_next   = s_tdata[0];
        end

        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        stage_adv_reg <= stage_adv_next;
        if (move)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       out_reg.dump_flag,
                       out_reg.projection_flag,
                       out_reg.commit_flag,
                       out_reg.index_next,
                       out_reg.index_current,
                       out_reg.index_previous,
                       out_reg.commit_step,
                       out_reg.day_of_sim,
                       out_reg.hour_of_day,
                       out_reg.elapsed_minutes,
                       out_reg.complete};

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (stage_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while a stage was free");

    a_move_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> out_valid_reg)
        else $error("processed tick produced no result");

endmodule
